[rtl/core/fbc_pkg.sv]
`timescale 1ns / 1ps

package fbc_pkg;

    // Widths of the address, the residue count and the record count.
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 16;
    localparam int KEPT_W = 32;

    // Number of result slots one input byte can fill.
    localparam int NUM_SLOTS = 6;

    // Slot positions, in delivery order.
    localparam int SLOT_DROP_PEND = 0;
    localparam int SLOT_WRITE     = 1;
    localparam int SLOT_HEADER    = 2;
    localparam int SLOT_SEQUENCE  = 3;
    localparam int SLOT_DROP_FIN  = 4;
    localparam int SLOT_DONE      = 5;

    // Special characters of the FASTA text.
    localparam logic [7:0] CH_HEADER  = 8'h3E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    // Configuration register indexes.
    localparam logic CFG_START_ADDRESS = 1'b0;
    localparam logic CFG_MIN_LENGTH    = 1'b1;

    typedef enum logic [2:0] {
        EV_WRITE    = 3'd0,
        EV_HEADER   = 3'd1,
        EV_SEQUENCE = 3'd2,
        EV_DROP     = 3'd3,
        EV_DONE     = 3'd4
    } t_event_kind;

    // All results caused by one input byte, held as fixed slots.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]             mask;
        logic [7:0]                       data;
        logic [NUM_SLOTS-1:0][ADDR_W-1:0] addr;
        logic [NUM_SLOTS-1:0][KEPT_W-1:0] kept;
    } t_bundle;

    // Event kind carried by each slot.
    function automatic t_event_kind slot_kind(input logic [2:0] slot);
        t_event_kind kind;
        case (slot)
            3'd0:    kind = EV_DROP;
            3'd1:    kind = EV_WRITE;
            3'd2:    kind = EV_HEADER;
            3'd3:    kind = EV_SEQUENCE;
            3'd4:    kind = EV_DROP;
            3'd5:    kind = EV_DONE;
            default: kind = EV_WRITE;
        endcase
        return kind;
    endfunction

endpackage

[rtl/core/fbc_front.sv]
`timescale 1ns / 1ps

module fbc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_index,
    input  logic [fbc_pkg::ADDR_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    input  logic [7:0]                     i_byte,
    input  logic                           i_final,
    input  logic                           i_queue_full,
    output logic                           o_ready,
    output logic                           o_push,
    output fbc_pkg::t_bundle               o_bundle
);

    logic [fbc_pkg::ADDR_W-1:0] r_start, n_start;
    logic [fbc_pkg::LEN_W-1:0]  r_min_len, n_min_len;
    logic [fbc_pkg::ADDR_W-1:0] r_wp, n_wp;
    logic                       r_in_hdr, n_in_hdr;
    logic                       r_in_seq, n_in_seq;
    logic [fbc_pkg::LEN_W-1:0]  r_res_cnt, n_res_cnt;
    logic [fbc_pkg::ADDR_W-1:0] r_hdr_start, n_hdr_start;
    logic                       r_rec_open, n_rec_open;
    logic [fbc_pkg::KEPT_W-1:0] r_rec_total, n_rec_total;
    logic                       r_nl_pend, n_nl_pend;

    logic accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign o_push  = accept;

    // Parse one byte: work out every result it causes and the next state.
    always_comb begin
        logic [fbc_pkg::ADDR_W-1:0] wp1;
        logic [fbc_pkg::KEPT_W-1:0] rt1;
        logic                       ro1, ih1, is1;
        logic                       is_hdr, is_nl, is_star;
        logic                       drop_fin;

        n_start     = r_start;
        n_min_len   = r_min_len;
        n_wp        = r_wp;
        n_in_hdr    = r_in_hdr;
        n_in_seq    = r_in_seq;
        n_res_cnt   = r_res_cnt;
        n_hdr_start = r_hdr_start;
        n_rec_open  = r_rec_open;
        n_rec_total = r_rec_total;
        n_nl_pend   = r_nl_pend;
        o_bundle    = '0;

        is_hdr  = (i_byte == fbc_pkg::CH_HEADER);
        is_nl   = (i_byte == fbc_pkg::CH_NEWLINE);
        is_star = (i_byte == fbc_pkg::CH_STAR);

        wp1 = r_wp;
        rt1 = r_rec_total;
        ro1 = r_rec_open;
        ih1 = r_in_hdr;
        is1 = r_in_seq;

        // A pending sequence line break is kept only when a header follows.
        if (r_nl_pend && is_hdr) begin
            if (r_rec_open && (r_res_cnt < r_min_len)) begin
                wp1 = r_hdr_start;
                rt1 = r_rec_total - 1'b1;
                ro1 = 1'b0;
                ih1 = 1'b0;
                is1 = 1'b0;
                o_bundle.mask[fbc_pkg::SLOT_DROP_PEND] = 1'b1;
                o_bundle.addr[fbc_pkg::SLOT_DROP_PEND] = r_hdr_start;
                o_bundle.kept[fbc_pkg::SLOT_DROP_PEND] = rt1;
            end else begin
                wp1 = r_wp + 1'b1;
            end
        end

        // The byte itself is always written.
        o_bundle.data                      = i_byte;
        o_bundle.mask[fbc_pkg::SLOT_WRITE] = 1'b1;
        o_bundle.addr[fbc_pkg::SLOT_WRITE] = wp1;
        o_bundle.kept[fbc_pkg::SLOT_WRITE] = rt1;

        n_wp        = wp1;
        n_rec_total = rt1;
        n_rec_open  = ro1;
        n_in_hdr    = ih1;
        n_in_seq    = is1;
        n_nl_pend   = 1'b0;

        // Classify the byte.
        if (is_hdr) begin
            n_hdr_start = wp1;
            n_rec_open  = 1'b1;
            n_in_hdr    = 1'b1;
            n_in_seq    = 1'b0;
            n_res_cnt   = '0;
            n_rec_total = rt1 + 1'b1;
            n_wp        = wp1 + 1'b1;
            o_bundle.mask[fbc_pkg::SLOT_HEADER] = 1'b1;
            o_bundle.addr[fbc_pkg::SLOT_HEADER] = wp1;
            o_bundle.kept[fbc_pkg::SLOT_HEADER] = rt1;
        end else if (is_nl) begin
            if (ih1 && !i_final) begin
                n_in_hdr = 1'b0;
                n_in_seq = 1'b1;
                n_wp     = wp1 + 1'b1;
                o_bundle.mask[fbc_pkg::SLOT_SEQUENCE] = 1'b1;
                o_bundle.addr[fbc_pkg::SLOT_SEQUENCE] = wp1 + 1'b1;
                o_bundle.kept[fbc_pkg::SLOT_SEQUENCE] = rt1;
            end else if (is1 && !i_final) begin
                n_nl_pend = 1'b1;
            end else begin
                n_wp = wp1 + 1'b1;
            end
        end else if (is_star) begin
            if (!is1) begin
                n_wp = wp1 + 1'b1;
            end
        end else begin
            if (is1 && (r_res_cnt != '1)) begin
                n_res_cnt = r_res_cnt + 1'b1;
            end
            n_wp = wp1 + 1'b1;
        end

        // The final byte closes the block and may drop the open record.
        if (i_final) begin
            drop_fin = n_rec_open && (n_res_cnt < r_min_len);
            if (drop_fin) begin
                n_wp        = n_hdr_start;
                n_rec_total = n_rec_total - 1'b1;
                o_bundle.mask[fbc_pkg::SLOT_DROP_FIN] = 1'b1;
                o_bundle.addr[fbc_pkg::SLOT_DROP_FIN] = n_hdr_start;
                o_bundle.kept[fbc_pkg::SLOT_DROP_FIN] = n_rec_total;
            end
            o_bundle.mask[fbc_pkg::SLOT_DONE] = 1'b1;
            o_bundle.addr[fbc_pkg::SLOT_DONE] = n_wp - 1'b1;
            o_bundle.kept[fbc_pkg::SLOT_DONE] = n_rec_total;

            n_wp        = r_start;
            n_in_hdr    = 1'b0;
            n_in_seq    = 1'b0;
            n_res_cnt   = '0;
            n_hdr_start = '0;
            n_rec_open  = 1'b0;
            n_rec_total = '0;
            n_nl_pend   = 1'b0;
        end

        // Without an accepted byte the parse state holds.
        if (!accept) begin
            n_wp        = r_wp;
            n_in_hdr    = r_in_hdr;
            n_in_seq    = r_in_seq;
            n_res_cnt   = r_res_cnt;
            n_hdr_start = r_hdr_start;
            n_rec_open  = r_rec_open;
            n_rec_total = r_rec_total;
            n_nl_pend   = r_nl_pend;
        end

        // Register writes; the start address also moves the write pointer.
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fbc_pkg::CFG_START_ADDRESS: begin
                    n_start = i_cfg_data;
                    n_wp    = i_cfg_data;
                end
                fbc_pkg::CFG_MIN_LENGTH: begin
                    n_min_len = i_cfg_data[fbc_pkg::LEN_W-1:0];
                end
                default: begin
                    n_start = r_start;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_min_len   <= fbc_pkg::LEN_W'(1);
            r_wp        <= '0;
            r_in_hdr    <= 1'b0;
            r_in_seq    <= 1'b0;
            r_res_cnt   <= '0;
            r_hdr_start <= '0;
            r_rec_open  <= 1'b0;
            r_rec_total <= '0;
            r_nl_pend   <= 1'b0;
        end else begin
            r_start     <= n_start;
            r_min_len   <= n_min_len;
            r_wp        <= n_wp;
            r_in_hdr    <= n_in_hdr;
            r_in_seq    <= n_in_seq;
            r_res_cnt   <= n_res_cnt;
            r_hdr_start <= n_hdr_start;
            r_rec_open  <= n_rec_open;
            r_rec_total <= n_rec_total;
            r_nl_pend   <= n_nl_pend;
        end
    end

endmodule

[rtl/core/fbc_queue.sv]
`timescale 1ns / 1ps

module fbc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fbc_pkg::t_bundle i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output fbc_pkg::t_bundle o_head
);

    fbc_pkg::t_bundle r_entry [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             do_pop;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_entry[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (do_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[rtl/core/fbc_back.sv]
`timescale 1ns / 1ps

module fbc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  fbc_pkg::t_bundle           i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output fbc_pkg::t_event_kind       o_kind,
    output logic [fbc_pkg::ADDR_W-1:0] o_addr,
    output logic [7:0]                 o_data,
    output logic [fbc_pkg::KEPT_W-1:0] o_kept,
    output logic                       o_last
);

    logic [fbc_pkg::NUM_SLOTS-1:0] r_done, n_done;
    logic                          r_valid, n_valid;
    fbc_pkg::t_event_kind          r_kind, n_kind;
    logic [fbc_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [7:0]                    r_data, n_data;
    logic [fbc_pkg::KEPT_W-1:0]    r_kept, n_kept;
    logic                          r_last, n_last;

    logic [fbc_pkg::NUM_SLOTS-1:0] remain;
    logic [fbc_pkg::NUM_SLOTS-1:0] sel;
    logic [2:0]                    sel_idx;
    logic                          load;
    logic                          is_last;

    assign remain  = i_head.mask & ~r_done;
    assign load    = i_head_valid && (!r_valid || i_ready);
    assign is_last = ((remain & ~sel) == '0);
    assign o_pop   = load && is_last;

    // Pick the earliest slot not yet delivered.
    always_comb begin
        sel     = '0;
        sel_idx = '0;
        for (int k = fbc_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            if (remain[k]) begin
                sel     = '0;
                sel[k]  = 1'b1;
                sel_idx = 3'(k);
            end
        end
    end

    // Output register and delivered-slot tracking.
    always_comb begin
        n_done  = r_done;
        n_valid = r_valid;
        n_kind  = r_kind;
        n_addr  = r_addr;
        n_data  = r_data;
        n_kept  = r_kept;
        n_last  = r_last;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_kind  = fbc_pkg::slot_kind(sel_idx);
            n_addr  = i_head.addr[sel_idx];
            n_data  = (sel_idx == 3'(fbc_pkg::SLOT_WRITE)) ? i_head.data : 8'd0;
            n_kept  = i_head.kept[sel_idx];
            n_last  = is_last;
            n_done  = is_last ? '0 : (r_done | sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_done  <= n_done;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_addr <= n_addr;
        r_data <= n_data;
        r_kept <= n_kept;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_addr;
    assign o_data  = r_data;
    assign o_kept  = r_kept;
    assign o_last  = r_last;

endmodule

[rtl/core/fasta_block_compactor.sv]
`timescale 1ns / 1ps

// FASTA block compactor.
// The slave stream takes one text byte per request, with tlast marking the
// final byte of a block. For each byte the master stream gives one to five
// results, each where it applies: a record drop, the byte write, header start,
// sequence start, record drop and block done; tlast marks the byte's last result.
// The configuration port sets the start address (which also loads the write
// pointer) and the minimum record length; write it only while the block is idle.
// A byte's result bundle is registered in the queue, and each of its results
// then in the output register. The parser takes one byte per cycle while the
// queue is not full; the output register gives one result per cycle while the
// receiver is ready, so plain bytes flow at one per cycle when nothing stalls.
// A two-entry queue of per-byte result bundles sits between parser and output;
// when the receiver stalls, the output holds, the queue fills and s_tready falls.
// Reset clears the parse state, sets the start address and write pointer to
// zero and the minimum length to one.
module fasta_block_compactor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] text_byte
    input  logic        i_s_tlast,    // final_byte
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,    // [31:0] address, [39:32] data_byte,
                                      // [71:40] kept_records
    output logic [2:0]  o_m_tuser,    // [2:0] event_kind
    output logic        o_m_tlast     // last_event
);

    logic                       push;
    fbc_pkg::t_bundle           push_data;
    logic                       queue_full;
    logic                       head_valid;
    fbc_pkg::t_bundle           head;
    logic                       pop;
    fbc_pkg::t_event_kind       out_kind;
    logic [fbc_pkg::ADDR_W-1:0] out_addr;
    logic [7:0]                 out_data;
    logic [fbc_pkg::KEPT_W-1:0] out_kept;

    fbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_tvalid),
        .i_byte       (i_s_tdata),
        .i_final      (i_s_tlast),
        .i_queue_full (queue_full),
        .o_ready      (o_s_tready),
        .o_push       (push),
        .o_bundle     (push_data)
    );

    fbc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    fbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (out_kind),
        .o_addr       (out_addr),
        .o_data       (out_data),
        .o_kept       (out_kept),
        .o_last       (o_m_tlast)
    );

    // Pack the result fields onto the master stream.
    assign o_m_tdata = {out_kept, out_data, out_addr};
    assign o_m_tuser = out_kind;

endmodule

[test/tb_fasta_block_compactor.sv]
`timescale 1ns / 1ps

module tb_fasta_block_compactor;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;

    // One expected result on the master stream.
    typedef struct {
        fbc_pkg::t_event_kind kind;
        logic [31:0]          addr;
        logic [7:0]           data;
        logic [31:0]          kept;
        logic                 last;
    } t_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [71:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    // Expected events in delivery order, and the mismatch count.
    t_result     pending_events[$];
    int          mismatches    = 0;
    int          stall_cycles  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [7:0]  text_q[$];

    // Predictor copy of the registers and the parse state.
    logic [31:0] start_addr_reg = '0;
    logic [15:0] min_len_reg    = 16'd1;
    logic [31:0] wr_ptr         = '0;
    logic [31:0] hdr_addr       = '0;
    logic [31:0] seq_addr       = '0;
    logic [31:0] kept_total     = '0;
    logic [15:0] residue_cnt    = '0;
    logic        in_header_line = 1'b0;
    logic        in_seq_line    = 1'b0;
    logic        record_live    = 1'b0;
    logic        break_pending  = 1'b0;

    fasta_block_compactor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Print one line per mismatch, up to a limit, and count them all.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    function automatic void push_result(input fbc_pkg::t_event_kind kind,
                                        input logic [31:0] addr, input logic [7:0] data);
        t_result r;
        r.kind = kind;
        r.addr = addr;
        r.data = data;
        r.kept = kept_total;
        r.last = 1'b0;
        pending_events.insert(pending_events.size(), r);
    endfunction

    function automatic void clear_parse_state();
        wr_ptr         = start_addr_reg;
        in_header_line = 1'b0;
        in_seq_line    = 1'b0;
        residue_cnt    = '0;
        hdr_addr       = '0;
        seq_addr       = '0;
        record_live    = 1'b0;
        kept_total     = '0;
        break_pending  = 1'b0;
    endfunction

    // A short record is withdrawn and the pointer goes back to its '>'.
    function automatic void drop_record();
        wr_ptr         = hdr_addr;
        kept_total     = kept_total - 1;
        record_live    = 1'b0;
        in_header_line = 1'b0;
        in_seq_line    = 1'b0;
        push_result(fbc_pkg::EV_DROP, hdr_addr, 8'h00);
    endfunction

    // Work out every event one text byte causes and queue them.
    function automatic void predict_byte(input logic [7:0] c, input logic fin);
        t_result tail;
        // A line break inside a sequence is only kept when a '>' follows.
        if (break_pending) begin
            break_pending = 1'b0;
            if (c == fbc_pkg::CH_HEADER) begin
                if (record_live && residue_cnt < min_len_reg) begin
                    drop_record();
                end else begin
                    wr_ptr = wr_ptr + 1;
                end
            end
        end
        push_result(fbc_pkg::EV_WRITE, wr_ptr, c);
        if (c == fbc_pkg::CH_HEADER) begin
            hdr_addr = wr_ptr;
            push_result(fbc_pkg::EV_HEADER, wr_ptr, 8'h00);
            record_live    = 1'b1;
            in_header_line = 1'b1;
            in_seq_line    = 1'b0;
            residue_cnt    = '0;
            kept_total     = kept_total + 1;
            wr_ptr         = wr_ptr + 1;
        end else if (c == fbc_pkg::CH_NEWLINE) begin
            if (in_header_line && !fin) begin
                seq_addr = wr_ptr + 1;
                push_result(fbc_pkg::EV_SEQUENCE, seq_addr, 8'h00);
                in_header_line = 1'b0;
                in_seq_line    = 1'b1;
                wr_ptr         = wr_ptr + 1;
            end else if (in_seq_line && !fin) begin
                break_pending = 1'b1;
            end else begin
                wr_ptr = wr_ptr + 1;
            end
        end else if (c == fbc_pkg::CH_STAR) begin
            if (!in_seq_line) begin
                wr_ptr = wr_ptr + 1;
            end
        end else begin
            if (in_seq_line && residue_cnt != 16'hFFFF) begin
                residue_cnt = residue_cnt + 16'd1;
            end
            wr_ptr = wr_ptr + 1;
        end
        // The final byte closes the block and restarts the parse.
        if (fin) begin
            if (record_live && residue_cnt < min_len_reg) begin
                drop_record();
            end
            push_result(fbc_pkg::EV_DONE, wr_ptr - 1, 8'h00);
            clear_parse_state();
        end
        tail = pending_events[pending_events.size() - 1];
        tail.last = 1'b1;
        pending_events[pending_events.size() - 1] = tail;
    endfunction

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], '0);
            end else begin
                want = pending_events.pop_front();
                if (o_m_tuser !== want.kind)
                    report_mismatch("event kind", {29'd0, o_m_tuser}, {29'd0, want.kind});
                if (o_m_tdata[31:0] !== want.addr)
                    report_mismatch("address", o_m_tdata[31:0], want.addr);
                if (o_m_tdata[39:32] !== want.data)
                    report_mismatch("data byte", {24'd0, o_m_tdata[39:32]}, {24'd0, want.data});
                if (o_m_tdata[71:40] !== want.kept)
                    report_mismatch("kept records", o_m_tdata[71:40], want.kept);
                if (o_m_tlast !== want.last)
                    report_mismatch("last event", {31'd0, o_m_tlast}, {31'd0, want.last});
            end
        end
    end

    // End the run when nothing moves on either stream for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one byte, idling first at random, and wait for the request to be taken.
    task automatic send_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_byte(c, fin);
    endtask

    // Send the buffered text; the last byte closes the block if asked.
    task automatic send_text(input bit close_block);
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], close_block && (i == text_q.size() - 1));
        end
        text_q.delete();
    endtask

    // Append one byte to the buffered text.
    function automatic void add_text(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_text(s[i]);
        end
    endtask

    // Wait until every expected result has arrived, then let the block settle.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes, back to back; the upper bits of a short register are junk.
    task automatic configure(input bit set_start, input logic [31:0] start,
                             input bit set_len, input logic [15:0] min_len);
        logic [15:0] junk;
        junk = 16'($urandom);
        if (set_start) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= fbc_pkg::CFG_START_ADDRESS;
            i_cfg_data  <= start;
            @(posedge i_clk);
            start_addr_reg = start;
            wr_ptr         = start;
        end
        if (set_len) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= fbc_pkg::CFG_MIN_LENGTH;
            i_cfg_data  <= {junk, min_len};
            @(posedge i_clk);
            min_len_reg = min_len;
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // A random byte that is none of the special characters.
    function automatic logic [7:0] residue_byte();
        logic [7:0] r;
        r = 8'($urandom_range(255));
        if (r == fbc_pkg::CH_HEADER || r == fbc_pkg::CH_NEWLINE || r == fbc_pkg::CH_STAR) begin
            r = 8'h41 + 8'($urandom_range(25));
        end
        return r;
    endfunction

    // Mostly well-formed records with lengths around the minimum, plus some noise.
    task automatic build_random_block(input int min_len);
        int n_rec;
        int n_res;
        int pos;
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 6)) add_text(8'($urandom_range(255)));
        end else begin
            n_rec = $urandom_range(1, 3);
            repeat (n_rec) begin
                add_text(fbc_pkg::CH_HEADER);
                repeat ($urandom_range(0, 3)) begin
                    add_text(($urandom_range(7) == 0) ? fbc_pkg::CH_STAR : residue_byte());
                end
                if ($urandom_range(9) != 0) add_text(fbc_pkg::CH_NEWLINE);
                n_res = $urandom_range(0, min_len + 3);
                repeat (n_res) begin
                    add_text(residue_byte());
                    if ($urandom_range(5) == 0) add_text(fbc_pkg::CH_STAR);
                    if ($urandom_range(3) == 0) add_text(fbc_pkg::CH_NEWLINE);
                end
                if ($urandom_range(1) == 0) add_text(fbc_pkg::CH_NEWLINE);
            end
            // Break the odd block with a random byte somewhere.
            if ($urandom_range(5) == 0) begin
                pos = $urandom_range(0, text_q.size() - 1);
                text_q[pos] = 8'($urandom_range(255));
            end
        end
    endtask

    // Stray breaks and stars, squeezed stars, kept and resolved line breaks.
    task automatic test_plain_records();
        push_string("\n*>h\nA*\nC\n>\n");
        add_text(8'hFF);
        add_text(8'h00);
        send_text(1'b1);
        wait_idle();
    endtask

    // Headers without a line break, a drop on a '>', a final break, wrapping address.
    task automatic test_short_records();
        configure(1'b1, 32'hFFFF_FFFC, 1'b1, 16'd2);
        push_string(">a>\nA\n>\nG\n");
        send_text(1'b1);
        wait_idle();
    endtask

    // Largest minimum: nothing is kept, so the end address wraps; the busiest byte.
    task automatic test_extreme_lengths();
        configure(1'b1, 32'h0000_0000, 1'b1, 16'hFFFF);
        push_string(">\n");
        send_text(1'b1);
        push_string(">\nA\n>");
        send_text(1'b1);
        wait_idle();
    endtask

    // Zero minimum, and a start address moved while a block is open.
    task automatic test_start_moved_mid_block();
        configure(1'b1, 32'h8000_0000, 1'b1, 16'd0);
        push_string(">x");
        send_text(1'b0);
        wait_idle();
        configure(1'b1, 32'h0000_1000, 1'b0, 16'd0);
        push_string("\nT");
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_random_blocks(input int n_items, input logic [31:0] start,
                                      input logic [15:0] min_len);
        int sent;
        sent = 0;
        configure(1'b1, start, 1'b1, min_len);
        while (sent < n_items) begin
            build_random_block(min_len);
            sent += text_q.size();
            send_text(1'b1);
        end
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles rarely, receiver often.
        send_idle_pct = 10;
        recv_idle_pct = 76;
        test_plain_records();
        test_short_records();
        test_extreme_lengths();
        test_start_moved_mid_block();
        test_random_blocks(100, 32'h0000_0040, 16'd3);

        // The other way round.
        send_idle_pct = 76;
        recv_idle_pct = 10;
        test_random_blocks(100, 32'hFFFF_FFFF, 16'd5);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_blocks(100, 32'h1234_5678, 16'd1);

        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (pending_events.size() != 0)
                report_mismatch("missing results", pending_events.size(), '0);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
